>>> hw/rtl/sita_pkg.sv
// Shared constants and control/status types for the signed integer to decimal text block.
package sita_pkg;

  // Width of the input word and of the unsigned magnitude.
  localparam int unsigned VALUE_W = 32;
  // Decimal digits needed for any 32-bit magnitude.
  localparam int unsigned DIGITS = 10;
  localparam int unsigned DIG_IDX_W = $clog2(DIGITS);
  // One conversion step per magnitude bit.
  localparam int unsigned BIT_CNT_W = $clog2(VALUE_W);
  localparam logic [BIT_CNT_W-1:0] BIT_CNT_LAST = BIT_CNT_W'(VALUE_W - 1);

  // ASCII codes.
  localparam int unsigned CHAR_W = 7;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'h39;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the input word and clear the digit register
    logic shift;       // one shift-add-3 conversion step
    logic find_lead;   // point the digit index at the leading digit
    logic emit_sign;   // write '-' into the output register
    logic emit_digit;  // write the indexed digit and step the index down
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic conv_last;   // the current shift is the final one
    logic negative;    // the captured value was negative
    logic out_free;    // the output register can take a character this cycle
    logic dig_zero;    // the digit index points at the least significant digit
  } sts_t;

endpackage

>>> hw/rtl/sita_if.sv
// Valid/ready channel interfaces for the input words and the output characters.
interface sita_in_if import sita_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sita_out_if import sita_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

>>> hw/rtl/sita_dpath.sv
// Datapath: magnitude and BCD shift registers, digit index and output register.
module sita_dpath import sita_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [VALUE_W-1:0] in_value,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [CHAR_W-1:0]  out_character,
  output logic               out_last
);

  logic [VALUE_W-1:0]          mag_r;
  logic [DIGITS-1:0][3:0]      bcd_r;
  logic                        neg_r;
  logic [BIT_CNT_W-1:0]        cnt_r;
  logic [DIG_IDX_W-1:0]        dig_r;
  logic                        out_valid_r;
  logic [CHAR_W-1:0]           out_char_r;
  logic                        out_last_r;

  logic [DIGITS-1:0][3:0]      bcd_adj;
  logic [DIGITS-1:0][3:0]      bcd_nxt;
  logic [DIG_IDX_W-1:0]        lead_idx;
  logic [3:0]                  cur_digit;
  logic                        out_free;

  // Each digit of 5 or more gets 3 added before the shift, so the shift doubles it correctly.
  // The top bit of the top digit is never set for a 32-bit magnitude, so it is dropped.
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      bcd_adj[i] = (bcd_r[i] >= 4'd5) ? bcd_r[i] + 4'd3 : bcd_r[i];
    end
    bcd_nxt = {bcd_adj[DIGITS-1][2:0], bcd_adj[DIGITS-2:0], mag_r[VALUE_W-1]};
  end

  // Leading digit: the highest nonzero one, or the lowest when all are zero.
  always_comb begin
    lead_idx = '0;
    for (int i = 1; i < DIGITS; i++) begin
      if (bcd_r[i] != 4'd0) begin
        lead_idx = DIG_IDX_W'(i);
      end
    end
  end

  assign cur_digit = bcd_r[dig_r];
  assign out_free  = !out_valid_r || out_ready;

  // Conversion registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_r <= in_value[VALUE_W-1] ? (~in_value + VALUE_W'(1)) : in_value;
      neg_r <= in_value[VALUE_W-1];
      bcd_r <= '0;
    end else if (cmd.shift) begin
      mag_r <= {mag_r[VALUE_W-2:0], 1'b0};
      bcd_r <= bcd_nxt;
    end
  end

  // Step counter and digit index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      dig_r <= '0;
    end else begin
      if (cmd.load) begin
        cnt_r <= '0;
      end else if (cmd.shift) begin
        cnt_r <= cnt_r + BIT_CNT_W'(1);
      end
      if (cmd.find_lead) begin
        dig_r <= lead_idx;
      end else if (cmd.emit_digit && dig_r != '0) begin
        dig_r <= dig_r - DIG_IDX_W'(1);
      end
    end
  end

  // Output register: holds one character until the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      out_char_r <= CHAR_MINUS;
      out_last_r <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_char_r <= CHAR_ZERO + {3'b000, cur_digit};
      out_last_r <= (dig_r == '0);
    end
  end

  assign sts.conv_last = (cnt_r == BIT_CNT_LAST);
  assign sts.negative  = neg_r;
  assign sts.out_free  = out_free;
  assign sts.dig_zero  = (dig_r == '0);

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

endmodule

>>> hw/rtl/sita_ctrl.sv
// Controller: sequences capture, conversion steps and character emission.
module sita_ctrl import sita_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CONV  = 3'd1;
  localparam logic [2:0] ST_LEAD  = 3'd2;
  localparam logic [2:0] ST_SIGN  = 3'd3;
  localparam logic [2:0] ST_DIGIT = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.shift = 1'b1;
        if (sts.conv_last) begin
          state_nxt = ST_LEAD;
        end
      end
      ST_LEAD: begin
        cmd.find_lead = 1'b1;
        state_nxt     = sts.negative ? ST_SIGN : ST_DIGIT;
      end
      ST_SIGN: begin
        if (sts.out_free) begin
          cmd.emit_sign = 1'b1;
          state_nxt     = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (sts.out_free) begin
          cmd.emit_digit = 1'b1;
          if (sts.dig_zero) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hw/rtl/signed_int_to_decimal_ascii.sv
// Top level: signed 32-bit integer to decimal ASCII characters, most significant first.
//
//   Channel  Dir  Payload                     Transaction
//   in_ch    in   value[31:0] signed          one integer to convert
//   out_ch   out  character[6:0], last        one ASCII character, last on the final one
//
// A word is captured, converted by 32 shift-add-3 steps (one magnitude bit a cycle
// through the BCD register) and its leading digit is found; then one character per
// cycle is emitted (up to 11) while the sink keeps taking them.
// The next word is accepted once the final character sits in the output register.
// A stalled sink holds the output register and the emitting state; conversion itself
// never stalls. Reset is synchronous and active low and clears only control state.
module signed_int_to_decimal_ascii import sita_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  sita_in_if.sink   in_ch,
  sita_out_if.source out_ch
);

  cmd_t cmd;
  sts_t sts;

  sita_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sita_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_value      (in_ch.value),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_character (out_ch.character),
    .out_last      (out_ch.last)
  );

  // A captured word keeps the input closed while it is converted.
  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted again right after a capture");

  // The final character of a run is always a digit.
  a_last_is_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.last) |->
      (out_ch.character >= CHAR_ZERO && out_ch.character <= CHAR_NINE))
    else $error("final character is not a digit");

  // Every character shown is a minus sign or a digit.
  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.character == CHAR_MINUS ||
      (out_ch.character >= CHAR_ZERO && out_ch.character <= CHAR_NINE)))
    else $error("illegal output character");

  // Conversion steps never coincide with emission.
  a_no_emit_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift |-> !(cmd.emit_sign || cmd.emit_digit || cmd.load))
    else $error("conversion step overlaps another command");

endmodule
